// ===== src/smau_pkg.sv =====
// Shared types, constants and helpers of the small matrix arithmetic unit.
package smau_pkg;

	localparam int MAX_DIM   = 8;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int DEPTH     = MAX_DIM * MAX_DIM;
	localparam int DIM_W     = 4;
	localparam int TOL_W     = 31;
	localparam int ACC_W     = 2 * DATA_W + IDX_W;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [2:0] {
		ACT_WR_A = 3'd0,
		ACT_WR_B = 3'd1,
		ACT_ADD  = 3'd2,
		ACT_SUB  = 3'd3,
		ACT_MUL  = 3'd4,
		ACT_CMP  = 3'd5
	} act_t;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_DIM = 2'd1,
		STAT_IDX = 2'd2
	} stat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A = 3'd0,
		REG_COLS_A = 3'd1,
		REG_ROWS_B = 3'd2,
		REG_COLS_B = 3'd3,
		REG_TOL    = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_EMIT
	} st_t;

	// A dimension register of zero acts as one, anything above the store size as the size.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] d;
		if (r == '0)
			d = DIM_W'(1);
		else if (r > DIM_W'(MAX_DIM))
			d = DIM_W'(MAX_DIM);
		else
			d = r;
		return d;
	endfunction

endpackage

// ===== src/small_matrix_arithmetic_unit_top.sv =====
// Top level of the small matrix arithmetic unit: sequencer, A and B stores, MAC path.
// A write goes straight to its store; an error result goes through the EMIT state into the output register.
// Each result element is built from K reads, K = cols_a for multiply and 1 otherwise, issued one at a time
// through the single read port of each store and the one multiply-accumulate path, then ISSUE, WAIT, EMIT.
// Compare walks its elements the same way and emits one result at the end.
// Reset sets the dimensions to one and the tolerance to zero, and clears control state and the per-entry valid bits, so both
// stores read as zero right after reset.
module small_matrix_arithmetic_unit_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [smau_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [smau_pkg::TOL_W-1:0]           cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [39:0]                          s_tdata,  // row[2:0], col[5:3], value[37:6], zero pad
	input  logic [2:0]                           s_tuser,  // action
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [39:0]                          m_tdata,  // row_res[2:0], col_res[5:3], result_value[37:6], is_equal[38], zero pad
	output logic [1:0]                           m_tuser,  // status
	output logic                                 m_tlast
);
	import smau_pkg::*;

	st_t state_q, state_d;

	logic [DIM_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [TOL_W-1:0] tol_q;

	logic [DATA_W-1:0] mem_a [DEPTH];
	logic [DATA_W-1:0] mem_b [DEPTH];
	logic [DEPTH-1:0]  va_q, vb_q;

	act_t             op_q;
	logic [DIM_W-1:0] ra_q, cn_q, kn_q;
	logic             direct_q;
	stat_t            status_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             eq_q;

	logic                     valid_s1, lastk_s1, va_s1, vb_s1;
	logic [DATA_W-1:0]        rd_a_s1, rd_b_s1;
	logic                     valid_s2, lastk_s2, mis_s2;
	logic signed [2*DATA_W-1:0] val_s2;
	logic                     fin_s3;
	logic signed [ACC_W-1:0]  acc_q;

	logic              out_valid_q, out_last_q, out_eq_q;
	stat_t             out_status_q;
	logic [IDX_W-1:0]  out_row_q, out_col_q;
	logic [DATA_W-1:0] out_val_q;

	// Request decode.
	act_t             act;
	logic [IDX_W-1:0] in_row, in_col;
	logic [DATA_W-1:0] in_val;
	logic [DIM_W-1:0] dra, dca, drb, dcb, wr_lr, wr_lc;
	logic             in_accept, is_wr, wr_bad, shape_eq, mul_ok, wr_ok;

	assign act       = act_t'(s_tuser);
	assign in_row    = s_tdata[2:0];
	assign in_col    = s_tdata[5:3];
	assign in_val    = s_tdata[37:6];
	assign dra       = clamp_dim(rows_a_q);
	assign dca       = clamp_dim(cols_a_q);
	assign drb       = clamp_dim(rows_b_q);
	assign dcb       = clamp_dim(cols_b_q);
	assign in_accept = s_tvalid && s_tready;
	assign is_wr     = (act == ACT_WR_A) || (act == ACT_WR_B);
	assign wr_lr     = (act == ACT_WR_A) ? dra : drb;
	assign wr_lc     = (act == ACT_WR_A) ? dca : dcb;
	assign wr_bad    = ({1'b0, in_row} >= wr_lr) || ({1'b0, in_col} >= wr_lc);
	assign shape_eq  = (dra == drb) && (dca == dcb);
	assign mul_ok    = (dca == drb);
	assign wr_ok     = in_accept && is_wr && !wr_bad;

	// Sequencer controls.
	logic issue_en, out_free, elem_last, k_last, need_out, emit_fire, out_load, start_elem;
	logic start_op, op_ok;

	assign out_free  = !out_valid_q || m_tready;
	assign elem_last = (({1'b0, i_q} + DIM_W'(1)) == ra_q) && (({1'b0, j_q} + DIM_W'(1)) == cn_q);
	assign k_last    = (({1'b0, k_q} + DIM_W'(1)) == kn_q);
	assign need_out  = direct_q || (op_q != ACT_CMP) || elem_last;

	always_comb begin
		case (act)
			ACT_ADD, ACT_SUB, ACT_CMP: op_ok = shape_eq;
			ACT_MUL:                   op_ok = mul_ok;
			default:                   op_ok = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					case (act)
						ACT_WR_A, ACT_WR_B:
							state_d = wr_bad ? ST_EMIT : ST_IDLE;
						ACT_ADD, ACT_SUB, ACT_MUL, ACT_CMP:
							state_d = op_ok ? ST_ISSUE : ST_EMIT;
						default:
							state_d = ST_IDLE;
					endcase
				end
			end
			ST_ISSUE: begin
				if (k_last)
					state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (fin_s3)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_fire)
					state_d = (direct_q || elem_last) ? ST_IDLE : ST_ISSUE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		issue_en  = 1'b0;
		emit_fire = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_ISSUE: issue_en = 1'b1;
			ST_WAIT:  ;
			ST_EMIT: begin
				emit_fire = need_out ? out_free : 1'b1;
				out_load  = need_out && out_free;
			end
			default:  ;
		endcase
	end

	assign start_op   = in_accept && !is_wr && op_ok;
	assign start_elem = emit_fire && !direct_q && !elem_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= DIM_W'(1);
			cols_a_q <= DIM_W'(1);
			rows_b_q <= DIM_W'(1);
			cols_b_q <= DIM_W'(1);
			tol_q    <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_addr))
				REG_ROWS_A: rows_a_q <= cfg_wdata[DIM_W-1:0];
				REG_COLS_A: cols_a_q <= cfg_wdata[DIM_W-1:0];
				REG_ROWS_B: rows_b_q <= cfg_wdata[DIM_W-1:0];
				REG_COLS_B: cols_b_q <= cfg_wdata[DIM_W-1:0];
				REG_TOL:    tol_q    <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	// Operation context and element counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= ACT_WR_A;
			ra_q     <= DIM_W'(1);
			cn_q     <= DIM_W'(1);
			kn_q     <= DIM_W'(1);
			direct_q <= 1'b0;
			status_q <= STAT_OK;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
		end else if (in_accept) begin
			op_q     <= act;
			ra_q     <= dra;
			cn_q     <= (act == ACT_MUL) ? dcb : dca;
			kn_q     <= (act == ACT_MUL) ? dca : DIM_W'(1);
			direct_q <= !op_ok;
			status_q <= is_wr ? STAT_IDX : ((act == ACT_CMP) ? STAT_OK : STAT_DIM);
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
		end else if (start_elem) begin
			k_q <= '0;
			if (({1'b0, j_q} + DIM_W'(1)) == cn_q) begin
				j_q <= '0;
				i_q <= i_q + IDX_W'(1);
			end else begin
				j_q <= j_q + IDX_W'(1);
			end
		end else if (issue_en) begin
			k_q <= k_q + IDX_W'(1);
		end
	end

	// Stores: valid bits make an entry read as zero until written.
	logic [ADDR_W-1:0] wr_addr, addr_a, addr_b;
	assign wr_addr = {in_row, in_col};
	assign addr_a  = (op_q == ACT_MUL) ? {i_q, k_q} : {i_q, j_q};
	assign addr_b  = (op_q == ACT_MUL) ? {k_q, j_q} : {i_q, j_q};

	always_ff @(posedge clk) begin
		if (wr_ok && act == ACT_WR_A)
			mem_a[wr_addr] <= in_val;
		if (wr_ok && act == ACT_WR_B)
			mem_b[wr_addr] <= in_val;
		if (issue_en) begin
			rd_a_s1 <= mem_a[addr_a];
			rd_b_s1 <= mem_b[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q     <= '0;
			vb_q     <= '0;
			valid_s1 <= 1'b0;
			lastk_s1 <= 1'b0;
			va_s1    <= 1'b0;
			vb_s1    <= 1'b0;
			valid_s2 <= 1'b0;
			lastk_s2 <= 1'b0;
			fin_s3   <= 1'b0;
		end else begin
			if (wr_ok && act == ACT_WR_A)
				va_q[wr_addr] <= 1'b1;
			if (wr_ok && act == ACT_WR_B)
				vb_q[wr_addr] <= 1'b1;
			valid_s1 <= issue_en;
			lastk_s1 <= issue_en && k_last;
			if (issue_en) begin
				va_s1 <= va_q[addr_a];
				vb_s1 <= vb_q[addr_b];
			end
			valid_s2 <= valid_s1;
			lastk_s2 <= valid_s1 && lastk_s1;
			fin_s3   <= valid_s2 && lastk_s2;
		end
	end

	// Arithmetic stage: product, sum or difference, and the tolerance check.
	logic signed [DATA_W-1:0] a_s1, b_s1;
	logic signed [DATA_W:0]   sum_s1, diff_s1;
	logic [DATA_W:0]          adiff_s1;

	assign a_s1     = va_s1 ? $signed(rd_a_s1) : '0;
	assign b_s1     = vb_s1 ? $signed(rd_b_s1) : '0;
	assign sum_s1   = {a_s1[DATA_W-1], a_s1} + {b_s1[DATA_W-1], b_s1};
	assign diff_s1  = {a_s1[DATA_W-1], a_s1} - {b_s1[DATA_W-1], b_s1};
	assign adiff_s1 = diff_s1[DATA_W] ? (DATA_W+1)'(-diff_s1) : diff_s1;

	always_ff @(posedge clk) begin
		case (op_q)
			ACT_MUL: val_s2 <= a_s1 * b_s1;
			ACT_SUB: val_s2 <= (2*DATA_W)'(diff_s1);
			default: val_s2 <= (2*DATA_W)'(sum_s1);
		endcase
		mis_s2 <= adiff_s1 > {2'b00, tol_q};
	end

	// Accumulator and compare flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			eq_q  <= 1'b1;
		end else begin
			if (start_op || start_elem)
				acc_q <= '0;
			else if (valid_s2)
				acc_q <= acc_q + ACC_W'(val_s2);
			if (start_op)
				eq_q <= 1'b1;
			else if (valid_s2 && mis_s2)
				eq_q <= 1'b0;
		end
	end

	// Scale a multiply result and saturate the finished element.
	logic signed [ACC_W-1:0] shifted;
	logic                    fits;
	logic [DATA_W-1:0]       sat_val;

	assign shifted = (op_q == ACT_MUL) ? (acc_q >>> FRAC_BITS) : acc_q;
	assign fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);
	assign sat_val = fits ? shifted[DATA_W-1:0] :
		(shifted[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});

	// Output register.
	logic plain;
	assign plain = direct_q || (op_q == ACT_CMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= direct_q ? status_q : STAT_OK;
			out_row_q    <= plain ? '0 : i_q;
			out_col_q    <= plain ? '0 : j_q;
			out_val_q    <= plain ? '0 : sat_val;
			out_eq_q     <= !direct_q && (op_q == ACT_CMP) && eq_q;
			out_last_q   <= direct_q || elem_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_eq_q, out_val_q, out_col_q, out_row_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_fin_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fin_s3 |-> state_q == ST_WAIT)
		else $error("element finished outside the wait state");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_tready))
		else $error("output register overwritten while held");
	a_pipe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (state_q == ST_ISSUE || state_q == ST_WAIT))
		else $error("arithmetic stage active while sequencer idle");
`endif

endmodule

// ===== tb/sv/smau_checker.sv =====
`timescale 1ns / 100ps
// Checker for the small matrix arithmetic unit: predicts results per request and compares them.
module smau_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [smau_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [smau_pkg::TOL_W-1:0]           cfg_wdata,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [39:0]                          s_tdata,
	input  logic [2:0]                           s_tuser,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [39:0]                          m_tdata,
	input  logic [1:0]                           m_tuser,
	input  logic                                 m_tlast,
	output int                                   fail_count,
	output int                                   pending
);
	import smau_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  row_res;
		logic [2:0]  col_res;
		logic [31:0] value;
		logic        is_equal;
		logic        last;
	} result_t;

	logic [DIM_W-1:0] rows_a, cols_a, rows_b, cols_b;
	logic [TOL_W-1:0] tol;
	logic signed [31:0] mat_a [DEPTH];
	logic signed [31:0] mat_b [DEPTH];
	result_t expected_results[$];

	function automatic logic signed [31:0] saturate(input logic signed [127:0] v);
		if (v > 128'sh7FFFFFFF)
			return 32'sh7FFFFFFF;
		if (v < -128'sh80000000)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic result_t make_result(input logic [1:0] st, input int r, input int c,
			input logic [31:0] v, input logic eq, input logic lst);
		result_t x;
		x.status = st;
		x.row_res = r[2:0];
		x.col_res = c[2:0];
		x.value = v;
		x.is_equal = eq;
		x.last = lst;
		return x;
	endfunction

	function automatic int clamp_dim_tb(input logic [DIM_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return d;
	endfunction

	task automatic predict_request(input logic [2:0] act, input logic [2:0] r,
			input logic [2:0] c, input logic signed [31:0] v);
		int ra, ca, rb, cb, lr, lc;
		logic signed [127:0] acc, diff;
		logic eq;
		ra = clamp_dim_tb(rows_a);
		ca = clamp_dim_tb(cols_a);
		rb = clamp_dim_tb(rows_b);
		cb = clamp_dim_tb(cols_b);
		case (act)
			ACT_WR_A, ACT_WR_B: begin
				lr = (act == ACT_WR_A) ? ra : rb;
				lc = (act == ACT_WR_A) ? ca : cb;
				if (r >= lr || c >= lc)
					expected_results.push_back(make_result(STAT_IDX, 0, 0, 0, 0, 1));
				else if (act == ACT_WR_A)
					mat_a[r * MAX_DIM + c] = v;
				else
					mat_b[r * MAX_DIM + c] = v;
			end
			ACT_ADD, ACT_SUB: begin
				if (ra != rb || ca != cb)
					expected_results.push_back(make_result(STAT_DIM, 0, 0, 0, 0, 1));
				else
					for (int i = 0; i < ra; i++)
						for (int j = 0; j < ca; j++) begin
							if (act == ACT_ADD)
								acc = 128'(mat_a[i*MAX_DIM+j]) + 128'(mat_b[i*MAX_DIM+j]);
							else
								acc = 128'(mat_a[i*MAX_DIM+j]) - 128'(mat_b[i*MAX_DIM+j]);
							expected_results.push_back(make_result(STAT_OK, i, j, saturate(acc),
								0, i + 1 == ra && j + 1 == ca));
						end
			end
			ACT_MUL: begin
				if (ca != rb)
					expected_results.push_back(make_result(STAT_DIM, 0, 0, 0, 0, 1));
				else
					for (int i = 0; i < ra; i++)
						for (int j = 0; j < cb; j++) begin
							acc = 0;
							for (int k = 0; k < ca; k++)
								acc += 128'(mat_a[i*MAX_DIM+k]) * 128'(mat_b[k*MAX_DIM+j]);
							acc = acc >>> FRAC_BITS;
							expected_results.push_back(make_result(STAT_OK, i, j, saturate(acc),
								0, i + 1 == ra && j + 1 == cb));
						end
			end
			ACT_CMP: begin
				eq = 1;
				if (ra != rb || ca != cb)
					eq = 0;
				else
					for (int i = 0; i < ra; i++)
						for (int j = 0; j < ca; j++) begin
							diff = 128'(mat_a[i*MAX_DIM+j]) - 128'(mat_b[i*MAX_DIM+j]);
							if (diff < 0)
								diff = -diff;
							if (diff > 128'(tol))
								eq = 0;
						end
				expected_results.push_back(make_result(STAT_OK, 0, 0, 0, eq, 1));
			end
			default: ;
		endcase
	endtask

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		result_t got, exp_r;
		if (!arst_n) begin
			rows_a <= 1;
			cols_a <= 1;
			rows_b <= 1;
			cols_b <= 1;
			tol <= 0;
			fail_count <= 0;
			for (int i = 0; i < DEPTH; i++) begin
				mat_a[i] = 0;
				mat_b[i] = 0;
			end
			expected_results.delete();
		end else begin
			if (cfg_wr_en)
				case (cfg_addr)
					REG_ROWS_A: rows_a <= cfg_wdata[DIM_W-1:0];
					REG_COLS_A: cols_a <= cfg_wdata[DIM_W-1:0];
					REG_ROWS_B: rows_b <= cfg_wdata[DIM_W-1:0];
					REG_COLS_B: cols_b <= cfg_wdata[DIM_W-1:0];
					REG_TOL:    tol <= cfg_wdata;
					default: ;
				endcase
			if (m_tvalid && m_tready) begin
				got = make_result(m_tuser, m_tdata[2:0], m_tdata[5:3], m_tdata[37:6],
					m_tdata[38], m_tlast);
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected st=%0d r=%0d c=%0d v=%h eq=%b last=%b",
							$time, exp_r.status, exp_r.row_res, exp_r.col_res, exp_r.value,
							exp_r.is_equal, exp_r.last);
						$display("%0t:          actual   st=%0d r=%0d c=%0d v=%h eq=%b last=%b",
							$time, got.status, got.row_res, got.col_res, got.value,
							got.is_equal, got.last);
						fail_count <= fail_count + 1;
					end
				end
			end
			// Prediction after the pop, so results of this request never pair with it early.
			if (s_tvalid && s_tready)
				predict_request(s_tuser, s_tdata[2:0], s_tdata[5:3], s_tdata[37:6]);
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, stimulus, receiver stalls and the verdict.
module testbench;
	import smau_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [TOL_W-1:0]     cfg_wdata;
	logic                 s_tvalid, s_tready;
	logic [39:0]          s_tdata;
	logic [2:0]           s_tuser;
	logic                 m_tvalid, m_tready;
	logic [39:0]          m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;
	int                   fail_count, pending;
	int                   cycles;
	bit                   quiet_phase;
	bit                   hold_off;

	small_matrix_arithmetic_unit_top i_dut (.*);

	smau_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 2000000) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Receiver: random stalls, none in the quiet phase, and one long hold-off on request.
	initial begin
		int stall;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 0;
				for (stall = 0; stall < 300; stall++)
					@(posedge clk);
				hold_off = 0;
			end
			m_tready <= quiet_phase || $urandom_range(99) >= 9;
		end
	end

	task automatic send(input logic [2:0] act, input logic [2:0] r, input logic [2:0] c,
			input logic [31:0] v);
		while (!quiet_phase && $urandom_range(99) < 9) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= act;
		s_tdata <= {2'b0, v, c, r};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain_and_pause();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [TOL_W-1:0] val);
		cfg_wr_en <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	task automatic set_dims(input int ra, input int ca, input int rb, input int cb);
		write_reg(REG_ROWS_A, TOL_W'(ra));
		write_reg(REG_COLS_A, TOL_W'(ca));
		write_reg(REG_ROWS_B, TOL_W'(rb));
		write_reg(REG_COLS_B, TOL_W'(cb));
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(3) << 16;
			3: return $urandom_range(255);
			default: return $urandom;
		endcase
	endfunction

	// Loads the used part of both matrices, sometimes with B set close to A.
	task automatic load_matrices(input int ra, input int ca, input int rb, input int cb,
			input bit similar);
		logic [31:0] v;
		for (int i = 0; i < ra; i++)
			for (int j = 0; j < ca; j++) begin
				v = rand_value();
				send(ACT_WR_A, 3'(i), 3'(j), v);
				if (similar && i < rb && j < cb)
					send(ACT_WR_B, 3'(i), 3'(j), v + $urandom_range(3) - 32'd1);
			end
		if (!similar)
			for (int i = 0; i < rb; i++)
				for (int j = 0; j < cb; j++)
					send(ACT_WR_B, 3'(i), 3'(j), rand_value());
	endtask

	initial begin
		int ra, ca, rb, cb, sent;
		logic [2:0] act;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_addr = 0;
		cfg_wdata = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		quiet_phase = 0;
		hold_off = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset state, 1x1 extremes, index error, ignored actions.
		send(ACT_ADD, 0, 0, 0);
		send(ACT_CMP, 0, 0, 0);
		send(ACT_WR_A, 0, 0, 32'h7FFFFFFF);
		send(ACT_WR_B, 0, 0, 32'h7FFFFFFF);
		send(ACT_ADD, 0, 0, 0);
		send(ACT_MUL, 0, 0, 0);
		send(ACT_WR_B, 0, 0, 32'h80000000);
		send(ACT_SUB, 0, 0, 0);
		send(ACT_MUL, 0, 0, 0);
		send(ACT_WR_A, 7, 7, 32'hFFFFFFFF);
		send(ACT_WR_B, 0, 1, 0);
		send(3'd6, 7, 7, 32'hFFFFFFFF);
		send(3'd7, 0, 0, 0);
		send(ACT_CMP, 0, 0, 0);
		drain_and_pause();
		// Out-of-range dimensions clamp; mismatched shapes; max tolerance.
		set_dims(0, 15, 1, 8);
		write_reg(REG_TOL, 31'h7FFFFFFF);
		send(ACT_ADD, 0, 0, 0);
		send(ACT_CMP, 0, 0, 0);
		send(ACT_WR_A, 0, 7, 32'h80000000);
		send(ACT_MUL, 0, 0, 0);
		drain_and_pause();
		set_dims(8, 8, 8, 8);
		write_reg(REG_TOL, 0);
		send(ACT_MUL, 0, 0, 0);
		send(ACT_CMP, 0, 0, 0);
		drain_and_pause();

		// Random: load-then-operate phases with random shapes, stray writes and unused actions.
		sent = 0;
		for (int ph = 0; sent < 210; ph++) begin
			quiet_phase = (ph % 6) == 3;
			ra = $urandom_range(ph % 5 == 0 ? 8 : 3, 1);
			ca = $urandom_range(ph % 5 == 0 ? 8 : 3, 1);
			case ($urandom_range(3))
				0: begin rb = ra; cb = ca; end
				1: begin rb = ca; cb = $urandom_range(3, 1); end
				default: begin rb = $urandom_range(3, 1); cb = $urandom_range(3, 1); end
			endcase
			set_dims(ra, ca, rb, cb);
			write_reg(REG_TOL, TOL_W'($urandom_range(2) == 0 ? $urandom : $urandom_range(2)));
			if (ph == 2)
				hold_off = 1;
			load_matrices(ra, ca, rb, cb, $urandom_range(1));
			sent += ra * ca + rb * cb;
			repeat (6) begin
				act = 3'($urandom_range(5, 2));
				if ($urandom_range(9) == 0)
					send(3'($urandom_range(1)), 3'($urandom), 3'($urandom), $urandom);
				else if ($urandom_range(19) == 0)
					send(3'($urandom_range(7, 6)), 3'($urandom), 3'($urandom), $urandom);
				else
					send(act, 3'($urandom), 3'($urandom), $urandom);
				sent++;
			end
			drain_and_pause();
		end
		quiet_phase = 0;

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
